// File: sv/sysex_firmware_block_framer_defines.svh
// assertion macros for the sysex block framer
`ifndef SYSEX_FIRMWARE_BLOCK_FRAMER_DEFINES_SVH
`define SYSEX_FIRMWARE_BLOCK_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define SFBF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfbf check failed");

// next-cycle implication, checked out of reset
`define SFBF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfbf check failed");

`else

`define SFBF_ASSERT_NOW(label, ante, cons)
`define SFBF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: sv/sfbf_pkg.sv
`default_nettype none

package sfbf_pkg;

   // default block size in bytes
   localparam int BLOCK_BYTES_DEF = 64;

   // input item codes
   localparam logic [1:0] MODE_DATA   = 2'd0;
   localparam logic [1:0] MODE_PAD    = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;
   localparam logic [1:0] MODE_RSVD   = 2'd3;

   // sysex stream bytes
   localparam logic [7:0] SOX_BYTE   = 8'hF0;
   localparam logic [7:0] MFR0_BYTE  = 8'h00;
   localparam logic [7:0] MFR1_BYTE  = 8'h13;
   localparam logic [7:0] CMD_BLOCK  = 8'h01;
   localparam logic [7:0] CMD_CLOSE  = 8'h03;
   localparam logic [7:0] EOX_BYTE   = 8'hF7;

   // configuration port
   localparam int          CSR_ADDR_W      = 3;
   localparam logic        CSR_IDX_DEVICE  = 1'b0;
   localparam logic [6:0]  DEVICE_ID_RESET = 7'd56;

   // job queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // one job: the output run caused by one input item
   typedef struct packed {
      logic             is_finish;
      logic             hdr;
      logic             flush;
      logic             trailer;
      logic [2:0]       last_idx;
      logic [6:0]       hi;
      logic [6:0][6:0]  grp;
      logic [27:0]      addr;
      logic [6:0]       chk;
      logic [15:0]      len;
      logic [15:0]      sum;
   } job_type;

   // queue status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // block size clamped to what a frame can carry
   function automatic int eff_block(input int b);
      int r;
      r = b;
      if (b < 2) begin
         r = 2;
      end else if (b > 127) begin
         r = 127;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/sfbf_front.sv
`default_nettype none

module sfbf_front #(
   parameter int BLOCK_BYTES = sfbf_pkg::BLOCK_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [1:0]        mode,
   input  wire logic [7:0]        data_byte,
   output sfbf_pkg::job_type      job,
   output logic                   push
);

   localparam int         EFF      = sfbf_pkg::eff_block(BLOCK_BYTES);
   localparam logic [6:0] EFF7     = 7'(EFF);
   localparam logic [2:0] POS_LAST = 3'd6;

   logic [27:0] addr_ff, addr_in;
   logic [6:0]  bib_ff, bib_in;
   logic [2:0]  pos_ff, pos_in;
   logic [6:0]  hi_ff, hi_in;
   logic [6:0]  xor_ff, xor_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        finished_ff, finished_in;
   logic [6:0]  grp_ff [7];

   logic        active, is_fin, first, blk_end, grp_end;
   logic [6:0]  c, hi_new, hdr_x, xor_c, xor_new, bib_inc;
   logic [6:0][6:0] grp_next;

   // classify the item
   assign active  = accept && !finished_ff && (mode != sfbf_pkg::MODE_RSVD);
   assign is_fin  = (mode == sfbf_pkg::MODE_FINISH);
   assign first   = (bib_ff == 7'd0);
   assign c       = data_byte[6:0];
   assign bib_inc = bib_ff + 7'd1;
   assign blk_end = (bib_inc == EFF7);
   assign grp_end = (pos_ff == POS_LAST) || blk_end;

   // high bits and running checksum
   assign hi_new  = (first ? 7'd0 : hi_ff) | (7'(data_byte[7]) << pos_ff);
   assign hdr_x   = sfbf_pkg::CMD_BLOCK[6:0] ^ EFF7 ^ addr_ff[6:0] ^ addr_ff[13:7]
                    ^ addr_ff[20:14] ^ addr_ff[27:21];
   assign xor_c   = (first ? hdr_x : xor_ff) ^ c;
   assign xor_new = grp_end ? (xor_c ^ hi_new) : xor_c;

   // group contents with this beat's byte in place
   always_comb begin
      for (int k = 0; k < 7; k++) begin
         grp_next[k] = (pos_ff == 3'(k)) ? c : grp_ff[k];
      end
   end

   // job for the back end
   always_comb begin
      job.is_finish = is_fin;
      job.hdr       = !is_fin && first;
      job.flush     = !is_fin && grp_end;
      job.trailer   = !is_fin && blk_end;
      job.last_idx  = pos_ff;
      job.hi        = hi_new;
      job.grp       = grp_next;
      job.addr      = addr_ff;
      job.chk       = xor_new;
      job.len       = cnt_ff;
      job.sum       = sum_ff;
   end

   assign push = active && (is_fin || first || grp_end);

   // next state
   always_comb begin
      addr_in     = addr_ff;
      bib_in      = bib_ff;
      pos_in      = pos_ff;
      hi_in       = hi_ff;
      xor_in      = xor_ff;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      finished_in = finished_ff;
      if (active) begin
         if (is_fin) begin
            finished_in = 1'b1;
            bib_in      = 7'd0;
            pos_in      = 3'd0;
            hi_in       = 7'd0;
         end else begin
            hi_in  = grp_end ? 7'd0 : hi_new;
            xor_in = xor_new;
            if (mode == sfbf_pkg::MODE_DATA) begin
               sum_in = sum_ff + 16'(data_byte);
               cnt_in = cnt_ff + 16'd1;
            end
            if (blk_end) begin
               bib_in  = 7'd0;
               pos_in  = 3'd0;
               addr_in = addr_ff + 28'(EFF);
            end else begin
               bib_in = bib_inc;
               pos_in = (pos_ff == POS_LAST) ? 3'd0 : pos_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         bib_ff      <= '0;
         pos_ff      <= '0;
         hi_ff       <= '0;
         xor_ff      <= '0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
         finished_ff <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         bib_ff      <= bib_in;
         pos_ff      <= pos_in;
         hi_ff       <= hi_in;
         xor_ff      <= xor_in;
         sum_ff      <= sum_in;
         cnt_ff      <= cnt_in;
         finished_ff <= finished_in;
      end
   end

   // group buffer, written before read within a group
   always_ff @(posedge clock) begin
      if (active && !is_fin) begin
         grp_ff[pos_ff] <= c;
      end
   end

endmodule

`default_nettype wire

// File: sv/sfbf_queue.sv
`default_nettype none

module sfbf_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire sfbf_pkg::job_type     job_in,
   input  wire logic                  pop,
   output sfbf_pkg::job_type          head,
   output sfbf_pkg::q_status_type     status
);

   sfbf_pkg::job_type mem [sfbf_pkg::Q_DEPTH];

   logic [sfbf_pkg::Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [sfbf_pkg::Q_CNT_W-1:0] count_ff;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == sfbf_pkg::Q_CNT_W'(sfbf_pkg::Q_DEPTH));
   assign head         = mem[rd_ptr_ff];

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= job_in;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// File: sv/sfbf_back.sv
`default_nettype none

`include "sysex_firmware_block_framer_defines.svh"

module sfbf_back #(
   parameter int BLOCK_BYTES = sfbf_pkg::BLOCK_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [6:0]            device_id,
   input  wire sfbf_pkg::job_type     head,
   input  wire sfbf_pkg::q_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_frame_end,
   output logic                       rsp_last_of_run
);

   localparam logic [6:0] EFF7     = 7'(sfbf_pkg::eff_block(BLOCK_BYTES));
   localparam logic [2:0] SEG_LAST = 3'd4;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_HDR  = 6'b000010,
      PH_INFO = 6'b000100,
      PH_GRP  = 6'b001000,
      PH_CHK  = 6'b010000,
      PH_END  = 6'b100000
   } phase_type;

   phase_type  phase_ff, phase_in, cur_ph, nxt_ph;
   logic [2:0] cnt_ff, cnt_in, cur_cnt, grp_idx, grp_last;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;
   logic       last_ff, last_in;

   logic       idle, have, go, seg_done, last;
   logic [7:0] cur_byte;

   // current position in the job's byte schedule
   assign idle     = (phase_ff == PH_IDLE);
   assign have     = !idle || !q_status.empty;
   assign cur_ph   = idle ? ((head.hdr || head.is_finish) ? PH_HDR : PH_GRP) : phase_ff;
   assign cur_cnt  = idle ? 3'd0 : cnt_ff;
   assign grp_idx  = cur_cnt - 3'd1;
   assign grp_last = head.last_idx + 3'd1;
   assign go       = have && (!valid_ff || !rsp_stall);

   // byte for this slot and the segment that follows
   always_comb begin
      cur_byte = sfbf_pkg::EOX_BYTE;
      seg_done = 1'b1;
      nxt_ph   = PH_IDLE;
      unique case (cur_ph)
         PH_HDR: begin
            seg_done = (cur_cnt == SEG_LAST);
            nxt_ph   = PH_INFO;
            unique case (cur_cnt)
               3'd0:    cur_byte = sfbf_pkg::SOX_BYTE;
               3'd1:    cur_byte = sfbf_pkg::MFR0_BYTE;
               3'd2:    cur_byte = sfbf_pkg::MFR1_BYTE;
               3'd3:    cur_byte = {1'b0, device_id};
               default: cur_byte = head.is_finish ? sfbf_pkg::CMD_CLOSE : sfbf_pkg::CMD_BLOCK;
            endcase
         end
         PH_INFO: begin
            seg_done = (cur_cnt == SEG_LAST);
            priority if (head.is_finish) begin
               nxt_ph = PH_END;
            end else if (head.flush) begin
               nxt_ph = PH_GRP;
            end else if (head.trailer) begin
               nxt_ph = PH_CHK;
            end else begin
               nxt_ph = PH_IDLE;
            end
            if (head.is_finish) begin
               unique case (cur_cnt)
                  3'd0:    cur_byte = {1'b0, head.len[6:0]};
                  3'd1:    cur_byte = {1'b0, head.len[13:7]};
                  3'd2:    cur_byte = {6'd0, head.len[15:14]};
                  3'd3:    cur_byte = {1'b0, head.sum[6:0]};
                  default: cur_byte = {1'b0, head.sum[13:7]};
               endcase
            end else begin
               unique case (cur_cnt)
                  3'd0:    cur_byte = {1'b0, EFF7};
                  3'd1:    cur_byte = {1'b0, head.addr[6:0]};
                  3'd2:    cur_byte = {1'b0, head.addr[13:7]};
                  3'd3:    cur_byte = {1'b0, head.addr[20:14]};
                  default: cur_byte = {1'b0, head.addr[27:21]};
               endcase
            end
         end
         PH_GRP: begin
            seg_done = (cur_cnt == grp_last);
            nxt_ph   = head.trailer ? PH_CHK : PH_IDLE;
            cur_byte = (cur_cnt == 3'd0) ? {1'b0, head.hi} : {1'b0, head.grp[grp_idx]};
         end
         PH_CHK: begin
            nxt_ph   = PH_END;
            cur_byte = {1'b0, head.chk};
         end
         PH_END: begin
            nxt_ph   = PH_IDLE;
            cur_byte = sfbf_pkg::EOX_BYTE;
         end
         default: begin
            nxt_ph   = PH_IDLE;
            cur_byte = sfbf_pkg::EOX_BYTE;
         end
      endcase
   end

   assign last = seg_done && (nxt_ph == PH_IDLE);
   assign pop  = go && last;

   // sequencer advance
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      if (go) begin
         if (seg_done) begin
            phase_in = nxt_ph;
            cnt_in   = 3'd0;
         end else begin
            phase_in = cur_ph;
            cnt_in   = cur_cnt + 3'd1;
         end
      end
   end

   // output register
   always_comb begin
      valid_in = valid_ff && rsp_stall;
      byte_in  = byte_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      if (go) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         end_in   = (cur_ph == PH_END);
         last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_frame_end   = end_ff;
   assign rsp_last_of_run = last_ff;

   // a job in progress always has its entry at the queue head
   `SFBF_ASSERT_NOW(a_job_present, phase_ff != PH_IDLE, !q_status.empty)
   // a terminator beat carries the end byte
   `SFBF_ASSERT_NOW(a_end_byte, valid_ff && end_ff, byte_ff == sfbf_pkg::EOX_BYTE)
   // group counter never runs past the group's last byte
   `SFBF_ASSERT_NOW(a_grp_bound, phase_ff == PH_GRP, cnt_ff <= grp_last)
   // finishing a job leaves the sequencer idle with the run marked
   `SFBF_ASSERT_NEXT(a_pop_idle, pop, phase_ff == PH_IDLE && valid_ff && last_ff)

endmodule

`default_nettype wire

// File: sv/sysex_firmware_block_framer.sv
// sysex firmware block framer
// req channel: one beat per firmware byte (mode 0), padding byte (mode 1) or finish
// (mode 2); a beat is taken when req_valid is high and req_stall is low.
// rsp channel: one beat per stream byte, with frame_end on each F7 terminator and
// last_of_run on the final byte caused by one req beat.
// csr port: device_id at byte address 0, read and write, reset value 56.
// the front end updates frame state in the cycle a beat is taken and queues a job for
// every beat that produces bytes; a two-entry job queue separates it from the back end.
// a run's first byte passes through the job queue and then the output register to rsp.
// the back end emits one byte per cycle while rsp_stall is low; a beat causes zero to
// eleven stream bytes, about 1.34 per byte over a 64-byte block.
// req_stall rises only while the job queue is full; beats that cause no output
// still pass through the front end at one per cycle while req_stall is low.
// while rsp_stall is high a valid byte stays in the output register and the back end
// waits. reset clears the queue, the output valid flag and all frame state but the group
// buffer; after a finish beat the block emits nothing more until the next reset.
`default_nettype none

module sysex_firmware_block_framer #(
   parameter int BLOCK_BYTES = sfbf_pkg::BLOCK_BYTES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_mode,
   input  wire logic [7:0]                        req_data_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [7:0]                             rsp_out_byte,
   output logic                                   rsp_frame_end,
   output logic                                   rsp_last_of_run,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [sfbf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   logic [6:0] dev_id_ff, dev_id_in;
   logic       csr_hit, req_accept, push, pop;

   sfbf_pkg::job_type       job, head;
   sfbf_pkg::q_status_type  q_status;

   // device id register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[sfbf_pkg::CSR_ADDR_W-1] == sfbf_pkg::CSR_IDX_DEVICE);
   assign csr_prdata = csr_hit ? {25'd0, dev_id_ff} : 32'd0;

   always_comb begin
      dev_id_in = dev_id_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         dev_id_in = csr_pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_id_ff <= sfbf_pkg::DEVICE_ID_RESET;
      end else begin
         dev_id_ff <= dev_id_in;
      end
   end

   // input handshake
   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   sfbf_front #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .mode      (req_mode),
      .data_byte (req_data_byte),
      .job       (job),
      .push      (push)
   );

   sfbf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .job_in (job),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   sfbf_back #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .device_id       (dev_id_ff),
      .head            (head),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int BLOCK_BYTES = sfbf_pkg::BLOCK_BYTES_DEF;
   localparam int ADDR_W      = sfbf_pkg::CSR_ADDR_W;
   // frame length as the block clamps it
   localparam int BLOCK_LEN = (BLOCK_BYTES < 2) ? 2 : ((BLOCK_BYTES > 127) ? 127 : BLOCK_BYTES);
   localparam logic [ADDR_W-1:0] DEVICE_ID_ADDR = ADDR_W'(4 * int'(sfbf_pkg::CSR_IDX_DEVICE));

   // one byte of the outgoing sysex stream
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       last_of_run;
   } stream_byte_type;

   // frame builder mirror plus the queue of stream bytes still owed by the block
   class sysex_scoreboard_type;
      stream_byte_type pending_bytes[$];
      int              fail_count;
      logic [6:0]      device_id;
      logic [27:0]     block_addr;
      int              fill;
      logic [6:0]      high_bits;
      logic [6:0]      group_low[7];
      logic [6:0]      frame_chk;
      logic [15:0]     byte_sum;
      logic [15:0]     byte_total;
      bit              closed;

      function new();
         device_id = sfbf_pkg::DEVICE_ID_RESET;
         block_addr = '0;
         fill = 0;
         high_bits = '0;
         foreach (group_low[i]) group_low[i] = '0;
         frame_chk = '0;
         byte_sum = '0;
         byte_total = '0;
         closed = 1'b0;
         fail_count = 0;
      endfunction

      function void report(string what, int want, int got);
         fail_count++;
         if (fail_count <= 100) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
         end
      endfunction

      function void push_byte(logic [7:0] b, logic is_end);
         stream_byte_type s;
         s.out_byte = b;
         s.frame_end = is_end;
         s.last_of_run = 1'b0;
         pending_bytes.push_back(s);
      endfunction

      function void push_header(logic [7:0] cmd);
         push_byte(sfbf_pkg::SOX_BYTE, 1'b0);
         push_byte(sfbf_pkg::MFR0_BYTE, 1'b0);
         push_byte(sfbf_pkg::MFR1_BYTE, 1'b0);
         push_byte({1'b0, device_id}, 1'b0);
         push_byte(cmd, 1'b0);
      endfunction

      // work out the stream bytes caused by one accepted req beat
      function void note_beat(logic [1:0] mode, logic [7:0] value);
         int              pos;
         int              start_n;
         stream_byte_type tail;
         start_n = pending_bytes.size();
         if (closed || mode == sfbf_pkg::MODE_RSVD) return;
         if (mode == sfbf_pkg::MODE_FINISH) begin
            // closing frame: count in 7-, 7- and 2-bit parts, low 14 bits of the sum
            push_header(sfbf_pkg::CMD_CLOSE);
            push_byte({1'b0, byte_total[6:0]}, 1'b0);
            push_byte({1'b0, byte_total[13:7]}, 1'b0);
            push_byte({6'd0, byte_total[15:14]}, 1'b0);
            push_byte({1'b0, byte_sum[6:0]}, 1'b0);
            push_byte({1'b0, byte_sum[13:7]}, 1'b0);
            push_byte(sfbf_pkg::EOX_BYTE, 1'b1);
            closed = 1'b1;
            fill = 0;
            high_bits = '0;
         end else begin
            // block header on the first beat of a block
            if (fill == 0) begin
               push_header(sfbf_pkg::CMD_BLOCK);
               push_byte(8'(BLOCK_LEN), 1'b0);
               frame_chk = sfbf_pkg::CMD_BLOCK[6:0] ^ 7'(BLOCK_LEN);
               for (int k = 0; k < 4; k++) begin
                  push_byte({1'b0, block_addr[7*k +: 7]}, 1'b0);
                  frame_chk ^= block_addr[7*k +: 7];
               end
               high_bits = '0;
            end
            pos = fill % 7;
            high_bits[pos] = value[7];
            group_low[pos] = value[6:0];
            frame_chk ^= value[6:0];
            // padding fills the frame but is not counted
            if (mode == sfbf_pkg::MODE_DATA) begin
               byte_sum += 16'(value);
               byte_total += 16'd1;
            end
            fill++;
            // group flush when full or when the block ends
            if (pos == 6 || fill >= BLOCK_LEN) begin
               push_byte({1'b0, high_bits}, 1'b0);
               frame_chk ^= high_bits;
               for (int k = 0; k <= pos; k++) push_byte({1'b0, group_low[k]}, 1'b0);
               high_bits = '0;
            end
            // checksum and terminator close the block
            if (fill >= BLOCK_LEN) begin
               push_byte({1'b0, frame_chk}, 1'b0);
               push_byte(sfbf_pkg::EOX_BYTE, 1'b1);
               block_addr += 28'(BLOCK_LEN);
               fill = 0;
            end
         end
         if (pending_bytes.size() > start_n) begin
            tail = pending_bytes.pop_back();
            tail.last_of_run = 1'b1;
            pending_bytes.push_back(tail);
         end
      endfunction

      // compare one rsp beat against the oldest owed byte
      function void check_byte(logic [7:0] b, logic is_end, logic is_last);
         stream_byte_type want;
         if (pending_bytes.size() == 0) begin
            fail_count++;
            $display("%0t ns: rsp beat %02h with nothing pending", $time, b);
            return;
         end
         want = pending_bytes.pop_front();
         if (want.out_byte !== b) report("out_byte", want.out_byte, b);
         if (want.frame_end !== is_end) report("frame_end", want.frame_end, is_end);
         if (want.last_of_run !== is_last) report("last_of_run", want.last_of_run, is_last);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic [1:0]            req_mode = sfbf_pkg::MODE_DATA;
   logic [7:0]            req_data_byte = 8'd0;
   logic                  rsp_stall = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr = '0;
   logic [31:0]           csr_pwdata = 32'd0;
   wire                   req_stall;
   wire                   rsp_valid;
   wire  [7:0]            rsp_out_byte;
   wire                   rsp_frame_end;
   wire                   rsp_last_of_run;
   wire  [31:0]           csr_prdata;
   wire                   csr_pready;

   int send_idle_pct = 0;
   int stall_pct = 0;

   sysex_scoreboard_type sb = new();

   sysex_firmware_block_framer #(.BLOCK_BYTES(BLOCK_BYTES)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #6 clock = ~clock;

   // random receiver stall
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // watch both channels; input beats are noted before results are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_beat(req_mode, req_data_byte);
         if (rsp_valid && !rsp_stall) sb.check_byte(rsp_out_byte, rsp_frame_end, rsp_last_of_run);
      end
   end

   // one req beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [1:0] mode, input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // device_id register access; a read is checked against the mirror
   task automatic csr_access(input logic is_write, input logic [6:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= DEVICE_ID_ADDR;
      csr_pwdata <= {25'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (is_write) begin
         sb.device_id = value;
      end else if (csr_prdata !== {25'd0, sb.device_id}) begin
         sb.report("device_id read", {25'd0, sb.device_id}, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and wait for every owed byte, then let the block settle
   task automatic drain(input int settle);
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_bytes.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      int         pick;
      logic [1:0] mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value, then the low extreme
      csr_access(1'b0, 7'd0);
      csr_access(1'b1, 7'd0);
      csr_access(1'b0, 7'd0);

      // directed: byte extremes, padding, the unused code
      send_beat(sfbf_pkg::MODE_DATA, 8'h00);
      send_beat(sfbf_pkg::MODE_DATA, 8'hFF);
      send_beat(sfbf_pkg::MODE_DATA, 8'h80);
      send_beat(sfbf_pkg::MODE_DATA, 8'h7F);
      send_beat(sfbf_pkg::MODE_RSVD, 8'hAA);
      send_beat(sfbf_pkg::MODE_PAD, 8'h00);
      send_beat(sfbf_pkg::MODE_PAD, 8'hFF);
      send_beat(sfbf_pkg::MODE_DATA, 8'h55);
      send_beat(sfbf_pkg::MODE_DATA, 8'hAA);
      send_beat(sfbf_pkg::MODE_RSVD, 8'h55);
      send_beat(sfbf_pkg::MODE_PAD, 8'h80);
      send_beat(sfbf_pkg::MODE_DATA, 8'h01);
      send_beat(sfbf_pkg::MODE_DATA, 8'hFE);
      send_beat(sfbf_pkg::MODE_PAD, 8'h7F);
      send_beat(sfbf_pkg::MODE_DATA, 8'h81);
      send_beat(sfbf_pkg::MODE_DATA, 8'h40);
      drain(10);

      // random phases, each with its own idling and device_id
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 66;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 66;
            end
            default: begin
               send_idle_pct = 31;
               stall_pct = 31;
            end
         endcase
         csr_access(1'b1, (phase == 0) ? 7'd127 : 7'($urandom_range(127)));
         csr_access(1'b0, 7'd0);
         for (int k = 0; k < 50; k++) begin
            pick = $urandom_range(99);
            mode = (pick < 78) ? sfbf_pkg::MODE_DATA
                 : ((pick < 94) ? sfbf_pkg::MODE_PAD : sfbf_pkg::MODE_RSVD);
            send_beat(mode, 8'($urandom_range(255)));
         end
         drain(10);
      end

      // finish inside a partly filled block, then beats that must be ignored
      if (sb.fill == 0) send_beat(sfbf_pkg::MODE_PAD, 8'($urandom_range(255)));
      send_beat(sfbf_pkg::MODE_FINISH, 8'($urandom_range(255)));
      send_beat(sfbf_pkg::MODE_DATA, 8'($urandom_range(255)));
      send_beat(sfbf_pkg::MODE_PAD, 8'($urandom_range(255)));
      send_beat(sfbf_pkg::MODE_FINISH, 8'($urandom_range(255)));
      send_beat(sfbf_pkg::MODE_RSVD, 8'($urandom_range(255)));
      drain(20);

      if (sb.pending_bytes.size() != 0) begin
         sb.fail_count++;
         $display("%0t ns: %0d stream bytes never arrived", $time, sb.pending_bytes.size());
      end
      if (sb.fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/sfbf_pkg.sv
sv/sfbf_front.sv
sv/sfbf_queue.sv
sv/sfbf_back.sv
sv/sysex_firmware_block_framer.sv
test/testbench.sv
